@@ hw/rtl/h264rd_pkg.sv @@
// ----------------------------------------------------------------------------
// h264rd_pkg
// Shared types and constants of the H.264 RTP depacketizer.
// ----------------------------------------------------------------------------
package h264rd_pkg;

  localparam logic [4:0] NalTypeMax  = 5'd12;
  localparam logic [4:0] NalTypeStap = 5'h18;
  localparam logic [4:0] NalTypeFuA  = 5'h1C;

  localparam logic [1:0] ModeSingle      = 2'd0;
  localparam logic [1:0] ModeNonInterlv  = 2'd1;
  localparam logic [1:0] ModeInterleaved = 2'd2;

  localparam logic [2:0] StartCodeLen = 3'd4;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_UNSUPPORTED  = 2'd1,
    ST_STAP_OVERRUN = 2'd2,
    ST_FU_SHORT     = 2'd3
  } status_e;

  // results caused by one input byte: start code, then data byte, then status
  typedef struct packed {
    logic [2:0] sc_cnt;
    logic       data_vld;
    logic [7:0] data;
    logic       nal_end;
    logic       stat_vld;
    status_e    stat;
  } burst_t;

endpackage

@@ hw/rtl/h264rd_if.sv @@
// ----------------------------------------------------------------------------
// h264rd_if
// Valid/ready channels of the depacketizer: payload bytes in, stream out.
// ----------------------------------------------------------------------------
interface h264rd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       first_of_packet;
  logic       last_of_packet;

  modport source (output valid, in_byte, first_of_packet, last_of_packet, input ready);
  modport sink   (input valid, in_byte, first_of_packet, last_of_packet, output ready);
endinterface

interface h264rd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       data_valid;
  logic       start_code_byte;
  logic       nal_complete;
  logic [1:0] status;
  logic       last_of_run;

  modport source (output valid, out_byte, data_valid, start_code_byte, nal_complete,
                  status, last_of_run, input ready);
  modport sink   (input valid, out_byte, data_valid, start_code_byte, nal_complete,
                  status, last_of_run, output ready);
endinterface

@@ hw/rtl/h264rd_parse.sv @@
// ----------------------------------------------------------------------------
// h264rd_parse
// Packet parser: tracks the packet state and decodes each byte into a burst.
// ----------------------------------------------------------------------------
module h264rd_parse (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_data_i,
  h264rd_in_if.sink            in_i,
  input  logic                 burst_rdy_i,
  output logic                 burst_vld_o,
  output h264rd_pkg::burst_t   burst_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SINGLE,
    PH_STAP_HI,
    PH_STAP_LO,
    PH_STAP_DATA,
    PH_FU_HDR,
    PH_FU_DATA
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  mode_q;
  logic [2:0]  ind_q, ind_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] left_q, left_d;
  logic        fu_end_q, fu_end_d;

  logic               acc;
  logic [7:0]         b;
  logic               last;
  logic [4:0]         nal_t;
  logic [15:0]        len;
  logic [15:0]        left_dec;
  h264rd_pkg::burst_t br;

  assign in_i.ready = burst_rdy_i;
  assign acc        = in_i.valid && in_i.ready;
  assign b          = in_i.in_byte;
  assign last       = in_i.last_of_packet;
  assign nal_t      = b[4:0];
  assign len        = {len_hi_q, b};
  assign left_dec   = left_q - 16'd1;

  always_comb begin
    phase_d  = phase_q;
    ind_d    = ind_q;
    len_hi_d = len_hi_q;
    left_d   = left_q;
    fu_end_d = fu_end_q;
    br       = '0;
    br.stat  = h264rd_pkg::ST_OK;
    if (acc) begin
      if (in_i.first_of_packet) begin
        phase_d = PH_IDLE;
        if ((mode_q == h264rd_pkg::ModeSingle || mode_q == h264rd_pkg::ModeNonInterlv)
            && nal_t >= 5'd1 && nal_t <= h264rd_pkg::NalTypeMax) begin
          br.sc_cnt   = h264rd_pkg::StartCodeLen;
          br.data_vld = 1'b1;
          br.data     = b;
          br.nal_end  = last;
          phase_d     = last ? PH_IDLE : PH_SINGLE;
        end else if (mode_q == h264rd_pkg::ModeNonInterlv
                     && nal_t == h264rd_pkg::NalTypeStap) begin
          phase_d = last ? PH_IDLE : PH_STAP_HI;
        end else if ((mode_q == h264rd_pkg::ModeNonInterlv
                      || mode_q == h264rd_pkg::ModeInterleaved)
                     && nal_t == h264rd_pkg::NalTypeFuA) begin
          ind_d = b[7:5];
          if (last) begin
            br.stat_vld = 1'b1;
            br.stat     = h264rd_pkg::ST_FU_SHORT;
          end else begin
            phase_d = PH_FU_HDR;
          end
        end else begin
          br.stat_vld = 1'b1;
          br.stat     = h264rd_pkg::ST_UNSUPPORTED;
        end
      end else begin
        unique case (phase_q)
          PH_SINGLE: begin
            br.data_vld = 1'b1;
            br.data     = b;
            br.nal_end  = last;
            if (last) phase_d = PH_IDLE;
          end
          PH_STAP_HI: begin
            len_hi_d = b;
            phase_d  = last ? PH_IDLE : PH_STAP_LO;
          end
          PH_STAP_LO: begin
            left_d = len;
            if (len == 16'd0) begin
              phase_d = PH_IDLE;
            end else if (last) begin
              br.stat_vld = 1'b1;
              br.stat     = h264rd_pkg::ST_STAP_OVERRUN;
              phase_d     = PH_IDLE;
            end else begin
              br.sc_cnt = h264rd_pkg::StartCodeLen;
              phase_d   = PH_STAP_DATA;
            end
          end
          PH_STAP_DATA: begin
            left_d      = left_dec;
            br.data_vld = 1'b1;
            br.data     = b;
            br.nal_end  = (left_dec == 16'd0);
            if (left_dec == 16'd0) begin
              phase_d = last ? PH_IDLE : PH_STAP_HI;
            end else if (last) begin
              br.stat_vld = 1'b1;
              br.stat     = h264rd_pkg::ST_STAP_OVERRUN;
              phase_d     = PH_IDLE;
            end
          end
          PH_FU_HDR: begin
            if (last) begin
              br.stat_vld = 1'b1;
              br.stat     = h264rd_pkg::ST_FU_SHORT;
              phase_d     = PH_IDLE;
            end else begin
              fu_end_d = b[6];
              if (b[7]) begin
                br.sc_cnt   = h264rd_pkg::StartCodeLen;
                br.data_vld = 1'b1;
                br.data     = {ind_q, b[4:0]};
              end
              phase_d = PH_FU_DATA;
            end
          end
          PH_FU_DATA: begin
            br.data_vld = 1'b1;
            br.data     = b;
            br.nal_end  = last && fu_end_q;
            if (last) phase_d = PH_IDLE;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign burst_o     = br;
  assign burst_vld_o = acc && ((br.sc_cnt != 3'd0) || br.data_vld || br.stat_vld);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      mode_q   <= h264rd_pkg::ModeSingle;
      ind_q    <= '0;
      len_hi_q <= '0;
      left_q   <= '0;
      fu_end_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      ind_q    <= ind_d;
      len_hi_q <= len_hi_d;
      left_q   <= left_d;
      fu_end_q <= fu_end_d;
      if (cfg_we_i) mode_q <= cfg_data_i;
    end
  end

endmodule

@@ hw/rtl/h264rd_emit.sv @@
// ----------------------------------------------------------------------------
// h264rd_emit
// Result register: holds one burst and sends its results one per transfer.
// ----------------------------------------------------------------------------
module h264rd_emit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 burst_vld_i,
  input  h264rd_pkg::burst_t   burst_i,
  output logic                 burst_rdy_o,
  h264rd_out_if.source         out_o
);

  h264rd_pkg::burst_t burst_q, burst_d;
  logic               busy_q, busy_d;
  logic               xfer;
  logic               final_res;

  always_comb begin
    out_o.out_byte        = 8'd0;
    out_o.data_valid      = 1'b0;
    out_o.start_code_byte = 1'b0;
    out_o.nal_complete    = 1'b0;
    out_o.status          = 2'(h264rd_pkg::ST_OK);
    final_res             = 1'b1;
    if (burst_q.sc_cnt != 3'd0) begin
      out_o.out_byte        = (burst_q.sc_cnt == 3'd1) ? 8'd1 : 8'd0;
      out_o.data_valid      = 1'b1;
      out_o.start_code_byte = 1'b1;
      final_res = (burst_q.sc_cnt == 3'd1) && !burst_q.data_vld && !burst_q.stat_vld;
    end else if (burst_q.data_vld) begin
      out_o.out_byte     = burst_q.data;
      out_o.data_valid   = 1'b1;
      out_o.nal_complete = burst_q.nal_end;
      final_res          = !burst_q.stat_vld;
    end else begin
      out_o.status = 2'(burst_q.stat);
    end
  end

  assign out_o.valid       = busy_q;
  assign out_o.last_of_run = final_res;
  assign xfer              = busy_q && out_o.ready;
  assign burst_rdy_o       = !busy_q || (xfer && final_res);

  always_comb begin
    burst_d = burst_q;
    busy_d  = busy_q;
    if (xfer) begin
      if (burst_q.sc_cnt != 3'd0) begin
        burst_d.sc_cnt = burst_q.sc_cnt - 3'd1;
      end else if (burst_q.data_vld) begin
        burst_d.data_vld = 1'b0;
      end else begin
        burst_d.stat_vld = 1'b0;
      end
      if (final_res) busy_d = 1'b0;
    end
    if (burst_vld_i && burst_rdy_o) begin
      burst_d = burst_i;
      busy_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    burst_q <= burst_d;
  end

endmodule

@@ hw/rtl/h264_rtp_depacketizer.sv @@
// latency: the first result of a byte is shown in the cycle after its transfer
// throughput: one input byte per cycle while each byte gives at most one result and the output is ready
// a byte that opens a NAL unit gives up to five results, and input stalls until the last of them leaves
// the single result register sets this rate; it takes the next burst as its last result leaves
// reset: packetization mode 0, parser idle, result register empty
// ----------------------------------------------------------------------------
// h264_rtp_depacketizer
// RTP H.264 payload (single NAL, STAP-A, FU-A) to Annex-B byte stream.
// ----------------------------------------------------------------------------
module h264_rtp_depacketizer (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_data_i,
  h264rd_in_if.sink    in_i,
  h264rd_out_if.source out_o
);

  h264rd_pkg::burst_t burst;
  logic               burst_vld;
  logic               burst_rdy;

  h264rd_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .burst_rdy_i (burst_rdy),
    .burst_vld_o (burst_vld),
    .burst_o     (burst)
  );

  h264rd_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .burst_vld_i (burst_vld),
    .burst_i     (burst),
    .burst_rdy_o (burst_rdy),
    .out_o       (out_o)
  );

  a_status_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.data_valid |-> out_o.status != 2'(h264rd_pkg::ST_OK)
      && out_o.last_of_run && out_o.out_byte == 8'd0)
    else $error("status-only result malformed");

  a_sc_is_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.start_code_byte |-> out_o.data_valid && !out_o.nal_complete)
    else $error("start code byte without data");

  a_stall_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("input stalled with empty result register");

  a_status_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != 2'(h264rd_pkg::ST_OK) |-> !out_o.data_valid)
    else $error("status on a data result");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the H.264 RTP depacketizer. A short table of
// directed payload bytes walks every packet type, each packetization mode and
// the dropped and truncated packets. Random packets follow: mostly well-formed
// single NAL, STAP-A and FU-A packets with random content, plus cut-short
// packets and loose bytes. Every Annex-B output transfer is compared field by
// field with a behavioral depacketizer kept inside the bench. Both channels
// idle in random bursts, and the output holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] ModeReject = 2'd3;
  localparam int ItemTarget    = 410;
  localparam int QuietTail     = 360;
  localparam int SettleCycles  = 8;
  localparam int HoldCycles    = 80;
  localparam int WatchdogLimit = 2000;

  typedef enum logic [2:0] {
    P_IDLE, P_SINGLE, P_STAP_HI, P_STAP_LO, P_STAP_DATA, P_FU_HDR, P_FU_DATA
  } parse_e;

  typedef struct packed {
    logic [7:0]          out_byte;
    logic                data_valid;
    logic                start_code_byte;
    logic                nal_complete;
    h264rd_pkg::status_e status;
    logic                last_of_run;
  } stream_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_SILENT, ROW_FLAG} row_e;

  typedef struct {
    logic [7:0]          b;
    bit                  f;
    bit                  l;
    bit                  cfg;
    logic [1:0]          mode;
    row_e                kind;
    h264rd_pkg::status_e st;
  } row_t;

  row_t dir_rows [29] = '{
    '{8'h55, 1'b0, 1'b0, 1'b0, h264rd_pkg::ModeSingle, ROW_SILENT, h264rd_pkg::ST_OK},
    '{8'h65, 1'b1, 1'b0, 1'b0, h264rd_pkg::ModeSingle, ROW_PREDICT, h264rd_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b1, 1'b0, h264rd_pkg::ModeSingle, ROW_PREDICT, h264rd_pkg::ST_OK},
    '{8'h01, 1'b1, 1'b1, 1'b0, h264rd_pkg::ModeSingle, ROW_PREDICT, h264rd_pkg::ST_OK},
    '{8'h8C, 1'b1, 1'b0, 1'b0, h264rd_pkg::ModeSingle, ROW_PREDICT, h264rd_pkg::ST_OK},
    '{8'h00, 1'b1, 1'b0, 1'b0, h264rd_pkg::ModeSingle, ROW_FLAG,
      h264rd_pkg::ST_UNSUPPORTED},
    '{8'hAA, 1'b0, 1'b1, 1'b0, h264rd_pkg::ModeSingle, ROW_SILENT, h264rd_pkg::ST_OK},
    '{8'h7C, 1'b1, 1'b1, 1'b0, h264rd_pkg::ModeSingle, ROW_FLAG,
      h264rd_pkg::ST_UNSUPPORTED},
    '{8'h78, 1'b1, 1'b0, 1'b1, h264rd_pkg::ModeNonInterlv, ROW_SILENT, h264rd_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, 1'b0, h264rd_pkg::ModeNonInterlv, ROW_SILENT, h264rd_pkg::ST_OK},
    '{8'h02, 1'b0, 1'b0, 1'b0, h264rd_pkg::ModeNonInterlv, ROW_PREDICT, h264rd_pkg::ST_OK},
    '{8'h67, 1'b0, 1'b0, 1'b0, h264rd_pkg::ModeNonInterlv, ROW_PREDICT, h264rd_pkg::ST_OK},
    '{8'h42, 1'b0, 1'b0, 1'b0, h264rd_pkg::ModeNonInterlv, ROW_PREDICT, h264rd_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, 1'b0, h264rd_pkg::ModeNonInterlv, ROW_SILENT, h264rd_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b0, 1'b0, h264rd_pkg::ModeNonInterlv, ROW_SILENT, h264rd_pkg::ST_OK},
    '{8'h18, 1'b1, 1'b0, 1'b0, h264rd_pkg::ModeNonInterlv, ROW_SILENT, h264rd_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b0, 1'b0, h264rd_pkg::ModeNonInterlv, ROW_SILENT, h264rd_pkg::ST_OK},
    '{8'hFF, 1'b0, 1'b1, 1'b0, h264rd_pkg::ModeNonInterlv, ROW_FLAG,
      h264rd_pkg::ST_STAP_OVERRUN},
    '{8'h9C, 1'b1, 1'b1, 1'b0, h264rd_pkg::ModeNonInterlv, ROW_FLAG,
      h264rd_pkg::ST_FU_SHORT},
    '{8'hFC, 1'b1, 1'b0, 1'b0, h264rd_pkg::ModeNonInterlv, ROW_SILENT, h264rd_pkg::ST_OK},
    '{8'hC5, 1'b0, 1'b0, 1'b0, h264rd_pkg::ModeNonInterlv, ROW_PREDICT, h264rd_pkg::ST_OK},
    '{8'hAB, 1'b0, 1'b0, 1'b0, h264rd_pkg::ModeNonInterlv, ROW_PREDICT, h264rd_pkg::ST_OK},
    '{8'hCD, 1'b0, 1'b1, 1'b0, h264rd_pkg::ModeNonInterlv, ROW_PREDICT, h264rd_pkg::ST_OK},
    '{8'h18, 1'b1, 1'b1, 1'b1, h264rd_pkg::ModeInterleaved, ROW_FLAG,
      h264rd_pkg::ST_UNSUPPORTED},
    '{8'h5C, 1'b1, 1'b0, 1'b0, h264rd_pkg::ModeInterleaved, ROW_SILENT, h264rd_pkg::ST_OK},
    '{8'h5F, 1'b0, 1'b0, 1'b0, h264rd_pkg::ModeInterleaved, ROW_PREDICT,
      h264rd_pkg::ST_OK},
    '{8'h00, 1'b0, 1'b1, 1'b0, h264rd_pkg::ModeInterleaved, ROW_PREDICT,
      h264rd_pkg::ST_OK},
    '{8'hDC, 1'b1, 1'b0, 1'b0, h264rd_pkg::ModeInterleaved, ROW_SILENT, h264rd_pkg::ST_OK},
    '{8'h41, 1'b1, 1'b1, 1'b1, ModeReject, ROW_FLAG, h264rd_pkg::ST_UNSUPPORTED}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_data_i;

  h264rd_in_if  in_if ();
  h264rd_out_if out_if ();

  h264_rtp_depacketizer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // behavioral depacketizer state
  logic [1:0]  pr_mode;
  parse_e      pr_phase;
  logic [2:0]  pr_fnri;
  logic [7:0]  pr_len_hi;
  logic [15:0] pr_left;
  logic        pr_fu_end;

  stream_t    run_q [$];
  stream_t    exp_q [$];
  logic [7:0] pkt [$];

  int err_cnt       = 0;
  int item_cnt      = 0;
  int idle_cycles   = 0;
  int src_gap_pct   = 0;
  int snk_stall_pct = 0;
  bit hold_req      = 1'b0;
  bit hold_done     = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void emit(logic [7:0] b, logic dv, logic sc, logic nc,
                               h264rd_pkg::status_e st);
    run_q.push_back('{b, dv, sc, nc, st, 1'b0});
  endfunction

  function automatic void start_code();
    emit(8'h00, 1'b1, 1'b1, 1'b0, h264rd_pkg::ST_OK);
    emit(8'h00, 1'b1, 1'b1, 1'b0, h264rd_pkg::ST_OK);
    emit(8'h00, 1'b1, 1'b1, 1'b0, h264rd_pkg::ST_OK);
    emit(8'h01, 1'b1, 1'b1, 1'b0, h264rd_pkg::ST_OK);
  endfunction

  function automatic void raise_status(h264rd_pkg::status_e st);
    emit(8'h00, 1'b0, 1'b0, 1'b0, st);
    pr_phase = P_IDLE;
  endfunction

  function automatic void depack_byte(logic [7:0] b, bit f, bit l, bit dry);
    logic [4:0] t;
    stream_t    tail;
    t = b[4:0];
    run_q.delete();
    if (f) begin
      pr_phase = P_IDLE;
      if ((pr_mode == h264rd_pkg::ModeSingle || pr_mode == h264rd_pkg::ModeNonInterlv) &&
          t >= 5'd1 && t <= h264rd_pkg::NalTypeMax) begin
        start_code();
        emit(b, 1'b1, 1'b0, l, h264rd_pkg::ST_OK);
        pr_phase = l ? P_IDLE : P_SINGLE;
      end else if (pr_mode == h264rd_pkg::ModeNonInterlv && t == h264rd_pkg::NalTypeStap) begin
        pr_phase = l ? P_IDLE : P_STAP_HI;
      end else if ((pr_mode == h264rd_pkg::ModeNonInterlv ||
                    pr_mode == h264rd_pkg::ModeInterleaved) &&
                   t == h264rd_pkg::NalTypeFuA) begin
        pr_fnri = b[7:5];
        if (l) raise_status(h264rd_pkg::ST_FU_SHORT);
        else pr_phase = P_FU_HDR;
      end else begin
        raise_status(h264rd_pkg::ST_UNSUPPORTED);
      end
    end else begin
      case (pr_phase)
        P_IDLE: ;
        P_SINGLE: begin
          emit(b, 1'b1, 1'b0, l, h264rd_pkg::ST_OK);
          if (l) pr_phase = P_IDLE;
        end
        P_STAP_HI: begin
          pr_len_hi = b;
          pr_phase = l ? P_IDLE : P_STAP_LO;
        end
        P_STAP_LO: begin
          pr_left = {pr_len_hi, b};
          if (pr_left == 16'd0) begin
            pr_phase = P_IDLE;
          end else if (l) begin
            raise_status(h264rd_pkg::ST_STAP_OVERRUN);
          end else begin
            start_code();
            pr_phase = P_STAP_DATA;
          end
        end
        P_STAP_DATA: begin
          pr_left = pr_left - 16'd1;
          emit(b, 1'b1, 1'b0, pr_left == 16'd0, h264rd_pkg::ST_OK);
          if (pr_left == 16'd0) pr_phase = l ? P_IDLE : P_STAP_HI;
          else if (l) raise_status(h264rd_pkg::ST_STAP_OVERRUN);
        end
        P_FU_HDR: begin
          if (l) begin
            raise_status(h264rd_pkg::ST_FU_SHORT);
          end else begin
            pr_fu_end = b[6];
            if (b[7]) begin
              start_code();
              emit({pr_fnri, b[4:0]}, 1'b1, 1'b0, 1'b0, h264rd_pkg::ST_OK);
            end
            pr_phase = P_FU_DATA;
          end
        end
        P_FU_DATA: begin
          emit(b, 1'b1, 1'b0, l && pr_fu_end, h264rd_pkg::ST_OK);
          if (l) pr_phase = P_IDLE;
        end
        default: ;
      endcase
    end
    if (run_q.size() > 0) begin
      tail = run_q.pop_back();
      tail.last_of_run = 1'b1;
      run_q.push_back(tail);
    end
    if (!dry) begin
      foreach (run_q[i]) exp_q.push_back(run_q[i]);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit f, input bit l, input bit dry);
    if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_if.valid           <= 1'b1;
    in_if.in_byte         <= b;
    in_if.first_of_packet <= f;
    in_if.last_of_packet  <= l;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    item_cnt++;
    depack_byte(b, f, l, dry);
  endtask

  task automatic set_mode(input logic [1:0] m);
    in_if.valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pr_mode = m;
  endtask

  task automatic gen_packet(output bit noise);
    int r;
    int n;
    int len;
    int cut;
    pkt.delete();
    noise = 1'b0;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      pkt.push_back({3'($urandom), 5'($urandom_range(1, 12))});
      n = $urandom_range(0, 7);
      repeat (n) pkt.push_back(8'($urandom));
    end else if (r < 58) begin
      pkt.push_back({3'($urandom), h264rd_pkg::NalTypeStap});
      n = $urandom_range(1, 3);
      repeat (n) begin
        len = $urandom_range(1, 5);
        pkt.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'h00);
        pkt.push_back(8'(len));
        repeat (len) pkt.push_back(8'($urandom));
      end
      if ($urandom_range(0, 5) == 0) begin
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        pkt.push_back(8'($urandom));
      end else if ($urandom_range(0, 5) == 0) begin
        pkt.push_back(8'($urandom));
      end
    end else if (r < 88) begin
      pkt.push_back({3'($urandom), h264rd_pkg::NalTypeFuA});
      pkt.push_back(8'($urandom));
      n = $urandom_range(0, 6);
      repeat (n) pkt.push_back(8'($urandom));
    end else begin
      noise = 1'b1;
      n = $urandom_range(1, 6);
      repeat (n) pkt.push_back(8'($urandom));
    end
    // cut-short packet
    if (!noise && $urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, pkt.size());
      while (pkt.size() > cut) void'(pkt.pop_back());
    end
  endtask

  // output side: random stalls and one long hold-off
  initial begin : sink_proc
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (snk_stall_pct != 0 && $urandom_range(0, 99) < snk_stall_pct) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic void cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin : stream_mon
    stream_t want;
    if (out_if.valid && out_if.ready) begin
      if (exp_q.size() == 0) begin
        $error("out_byte: expected no transfer, got 0x%0h", out_if.out_byte);
        err_cnt++;
      end else begin
        want = exp_q.pop_front();
        cmp_field("out_byte",        want.out_byte,        out_if.out_byte);
        cmp_field("data_valid",      want.data_valid,      out_if.data_valid);
        cmp_field("start_code_byte", want.start_code_byte, out_if.start_code_byte);
        cmp_field("nal_complete",    want.nal_complete,    out_if.nal_complete);
        cmp_field("status",          want.status,          out_if.status);
        cmp_field("last_of_run",     want.last_of_run,     out_if.last_of_run);
      end
    end
    if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stim_proc
    logic [1:0] phase_modes [5];
    logic [1:0] m;
    bit         noise;
    bit         f;
    bit         l;
    int         ph;
    int         npkt;
    phase_modes = '{h264rd_pkg::ModeNonInterlv, h264rd_pkg::ModeInterleaved,
                    h264rd_pkg::ModeSingle, ModeReject, h264rd_pkg::ModeNonInterlv};
    rst_ni                <= 1'b0;
    cfg_we_i              <= 1'b0;
    cfg_data_i            <= h264rd_pkg::ModeSingle;
    in_if.valid           <= 1'b0;
    in_if.in_byte         <= 8'h00;
    in_if.first_of_packet <= 1'b0;
    in_if.last_of_packet  <= 1'b0;
    pr_mode   = h264rd_pkg::ModeSingle;
    pr_phase  = P_IDLE;
    pr_fnri   = 3'd0;
    pr_len_hi = 8'd0;
    pr_left   = 16'd0;
    pr_fu_end = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_gap_pct   = 20;
    snk_stall_pct = 20;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg) set_mode(dir_rows[i].mode);
      send_byte(dir_rows[i].b, dir_rows[i].f, dir_rows[i].l,
                dir_rows[i].kind != ROW_PREDICT);
      if (dir_rows[i].kind == ROW_FLAG)
        exp_q.push_back('{8'h00, 1'b0, 1'b0, 1'b0, dir_rows[i].st, 1'b1});
    end

    ph = 0;
    while (item_cnt < ItemTarget) begin
      m = (ph < 5) ? phase_modes[ph] : 2'($urandom_range(0, 3));
      set_mode(m);
      if (item_cnt < QuietTail) begin
        src_gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : 10 * $urandom_range(1, 4);
        snk_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 10 * $urandom_range(1, 4);
      end
      npkt = $urandom_range(8, 14);
      repeat (npkt) begin
        if (item_cnt < ItemTarget) begin
          gen_packet(noise);
          foreach (pkt[k]) begin
            if (noise) begin
              f = ($urandom_range(0, 2) == 0);
              l = ($urandom_range(0, 2) == 0);
            end else begin
              f = (k == 0);
              l = (k == pkt.size() - 1);
            end
            send_byte(pkt[k], f, l, 1'b0);
            if (!hold_done && item_cnt >= 150) begin
              hold_req  = 1'b1;
              hold_done = 1'b1;
            end
            if (item_cnt >= QuietTail) begin
              src_gap_pct   = 0;
              snk_stall_pct = 0;
            end
          end
        end
      end
      ph++;
    end

    in_if.valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
